// File: hw/rtl/assert_macros.svh
// Assertion macros used by the centroid block's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant violated");
// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");
// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/wtce_pkg.sv
// Constants, register codes and sequencer states of the windowed centroid block.
`timescale 1ns / 1ps

package wtce_pkg;

   // image geometry
   localparam int IMG_W = 2048;
   localparam int IMG_H = 2048;

   // field widths
   localparam int PIX_W   = 8;
   localparam int COORD_W = 11;
   localparam int WIN_W   = 13;
   localparam int THR_W   = 9;
   localparam int CNT_W   = 23;
   localparam int SUM_W   = 34;
   localparam int ACC_W   = 32;
   localparam int NRG_W   = 31;
   localparam int CEN_W   = 19;

   // Q.8 centroid: fraction bits and the added half
   localparam int FRAC_W = 8;
   localparam logic [CEN_W-1:0] HALF_Q8 = CEN_W'(1 << (FRAC_W - 1));

   // divider: one quotient bit per step over the whole shifted dividend
   localparam int DVD_W     = SUM_W + FRAC_W;
   localparam int DIV_STEPS = DVD_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = WIN_W;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIN_LEFT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WIN_TOP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WIN_RIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WIN_BOTTOM = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_REF_NOISE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TEST_NOISE = 3'd6;

   // register reset values
   localparam logic [THR_W-1:0] THRESHOLD_RST = 9'd128;
   localparam logic [WIN_W-1:0] WIN_END_RST   = 13'd2047;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y,
      ST_EMIT
   } state_type;

endpackage

// File: hw/rtl/window_threshold_centroid_energy_top.sv
// Windowed, thresholded pixel centroid and energy sums with a shared serial divider.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Throughput: while idle, a request without frame_end is taken every cycle, accumulated on
// acceptance. A frame_end request stalls the input through ST_DIV_X, ST_DIV_Y and ST_EMIT:
// one restoring divider, one quotient bit per cycle, is used first for the column then for
// the row centroid; both are skipped when no pixel counted. ST_EMIT registers the result once
// the result slot is free; it is held while rsp_stall is high. Reset (synchronous, active high)
// restores register defaults and clears accumulators, sequencer and the result valid.

module window_threshold_centroid_energy_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration write port
   input  logic                                 csr_write,
   input  logic [wtce_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wtce_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // pixel requests
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [wtce_pkg::PIX_W-1:0]           req_pixel,
   input  logic [wtce_pkg::COORD_W-1:0]         req_col,
   input  logic [wtce_pkg::COORD_W-1:0]         req_row,
   input  logic                                 req_frame_end,
   // per-frame results
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [wtce_pkg::CEN_W-1:0]           rsp_center_x,
   output logic [wtce_pkg::CEN_W-1:0]           rsp_center_y,
   output logic [wtce_pkg::CNT_W-1:0]           rsp_pixel_count,
   output logic signed [wtce_pkg::NRG_W-1:0]    rsp_ref_energy,
   output logic signed [wtce_pkg::NRG_W-1:0]    rsp_test_energy
);

   import wtce_pkg::*;

   // ---------------------------------------------------------------- config
   logic [THR_W-1:0]        threshold_ff;
   logic signed [WIN_W-1:0] win_left_ff, win_top_ff, win_right_ff, win_bottom_ff;
   logic [PIX_W-1:0]        ref_noise_ff, test_noise_ff;

   // ---------------------------------------------------------- accumulators
   logic [CNT_W-1:0] count_ff,    count_in;
   logic [SUM_W-1:0] col_sum_ff,  col_sum_in;
   logic [SUM_W-1:0] row_sum_ff,  row_sum_in;
   logic [ACC_W-1:0] ref_acc_ff,  ref_acc_in;
   logic [ACC_W-1:0] test_acc_ff, test_acc_in;

   // ------------------------------------------------------------- sequencer
   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff;

   // -------------------------------------------------------------- divider
   logic [DVD_W-1:0] dvd_ff;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CEN_W-1:0] quo_ff, quo_in;
   logic [CNT_W:0]   rem_shift;
   logic             quo_bit;

   // ---------------------------------------------------------- result path
   logic [CEN_W-1:0] center_x_ff, center_y_ff;
   logic             rsp_valid_ff;
   logic [CEN_W-1:0] rsp_center_x_ff, rsp_center_y_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic [NRG_W-1:0] rsp_ref_ff, rsp_test_ff;

   logic req_accept, pix_hit, in_cols, in_rows, slot_free;
   logic div_step, div_last, emit_fire, start_div, skip_div;
   logic signed [WIN_W-1:0] col_s, row_s;

   // ------------------------------------------------------------- counting
   // Negative left/top need no clamp: coordinates are never negative.
   // The exclusive end is clamped by also comparing against the last column/row.
   assign col_s   = $signed({{(WIN_W-COORD_W){1'b0}}, req_col});
   assign row_s   = $signed({{(WIN_W-COORD_W){1'b0}}, req_row});
   assign in_cols = (col_s >= win_left_ff) && (col_s < win_right_ff)
                    && (32'(req_col) < 32'(IMG_W - 1));
   assign in_rows = (row_s >= win_top_ff) && (row_s < win_bottom_ff)
                    && (32'(req_row) < 32'(IMG_H - 1));
   assign pix_hit = in_cols && in_rows && ({1'b0, req_pixel} >= threshold_ff);

   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   // the divisions start from the count that includes the frame_end pixel
   assign start_div = req_accept && req_frame_end && (count_in != '0);
   assign skip_div  = req_accept && req_frame_end && (count_in == '0);
   assign div_last  = (step_ff == DIV_LAST);

   // ------------------------------------------------- sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_div) begin
               state_in = ST_DIV_X;
            end else if (skip_div) begin
               state_in = ST_EMIT;
            end
         end
         ST_DIV_X: begin
            if (div_last) begin
               state_in = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------- sequencer: outputs
   always_comb begin
      req_stall = 1'b1;
      div_step  = 1'b0;
      emit_fire = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_DIV_X: div_step  = 1'b1;
         ST_DIV_Y: div_step  = 1'b1;
         ST_EMIT:  emit_fire = slot_free;
         default:  req_stall = 1'b1;
      endcase
   end

   // ------------------------------------------------ accumulator next values
   always_comb begin
      count_in    = count_ff;
      col_sum_in  = col_sum_ff;
      row_sum_in  = row_sum_ff;
      ref_acc_in  = ref_acc_ff;
      test_acc_in = test_acc_ff;
      if (req_accept && pix_hit) begin
         count_in    = count_ff + CNT_W'(1);
         col_sum_in  = col_sum_ff + SUM_W'(req_col);
         row_sum_in  = row_sum_ff + SUM_W'(req_row);
         ref_acc_in  = ref_acc_ff + ACC_W'(req_pixel) - ACC_W'(ref_noise_ff);
         test_acc_in = test_acc_ff + ACC_W'(req_pixel) - ACC_W'(test_noise_ff);
      end else if (emit_fire) begin
         count_in    = '0;
         col_sum_in  = '0;
         row_sum_in  = '0;
         ref_acc_in  = '0;
         test_acc_in = '0;
      end
   end

   // --------------------------------------------- shared restoring divider
   // Partial remainder stays below the count, so one extra bit covers the shift.
   assign rem_shift = {rem_ff, dvd_ff[DVD_W-1]};
   assign quo_bit   = (rem_shift >= {1'b0, count_ff});
   assign rem_in    = quo_bit ? CNT_W'(rem_shift - {1'b0, count_ff})
                              : rem_shift[CNT_W-1:0];
   // only the low quotient bits survive the Q.8 result width
   assign quo_in    = {quo_ff[CEN_W-2:0], quo_bit};

   // ------------------------------------------------ control and state regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         threshold_ff  <= THRESHOLD_RST;
         win_left_ff   <= '0;
         win_top_ff    <= '0;
         win_right_ff  <= WIN_END_RST;
         win_bottom_ff <= WIN_END_RST;
         ref_noise_ff  <= '0;
         test_noise_ff <= '0;
         count_ff      <= '0;
         col_sum_ff    <= '0;
         row_sum_ff    <= '0;
         ref_acc_ff    <= '0;
         test_acc_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         col_sum_ff  <= col_sum_in;
         row_sum_ff  <= row_sum_in;
         ref_acc_ff  <= ref_acc_in;
         test_acc_ff <= test_acc_in;

         if (start_div || (div_step && div_last)) begin
            step_ff <= '0;
         end else if (div_step) begin
            step_ff <= step_ff + STEP_W'(1);
         end

         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_write) begin
            unique case (csr_index)
               REG_THRESHOLD:  threshold_ff  <= csr_wdata[THR_W-1:0];
               REG_WIN_LEFT:   win_left_ff   <= $signed(csr_wdata[WIN_W-1:0]);
               REG_WIN_TOP:    win_top_ff    <= $signed(csr_wdata[WIN_W-1:0]);
               REG_WIN_RIGHT:  win_right_ff  <= $signed(csr_wdata[WIN_W-1:0]);
               REG_WIN_BOTTOM: win_bottom_ff <= $signed(csr_wdata[WIN_W-1:0]);
               REG_REF_NOISE:  ref_noise_ff  <= csr_wdata[PIX_W-1:0];
               REG_TEST_NOISE: test_noise_ff <= csr_wdata[PIX_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // ------------------------------------------------------- payload regs
   always_ff @(posedge clock) begin
      if (start_div) begin
         dvd_ff <= {col_sum_in, FRAC_W'(0)};
         rem_ff <= '0;
      end else if (div_step && div_last && (state_ff == ST_DIV_X)) begin
         dvd_ff <= {row_sum_ff, FRAC_W'(0)};
         rem_ff <= '0;
      end else if (div_step) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end

      if (div_step) begin
         quo_ff <= quo_in;
      end

      if (skip_div) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (div_step && div_last && (state_ff == ST_DIV_X)) begin
         center_x_ff <= quo_in + HALF_Q8;
      end else if (div_step && div_last && (state_ff == ST_DIV_Y)) begin
         center_y_ff <= quo_in + HALF_Q8;
      end

      if (emit_fire) begin
         rsp_center_x_ff <= center_x_ff;
         rsp_center_y_ff <= center_y_ff;
         rsp_count_ff    <= count_ff;
         rsp_ref_ff      <= ref_acc_ff[NRG_W-1:0];
         rsp_test_ff     <= test_acc_ff[NRG_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_center_x    = rsp_center_x_ff;
   assign rsp_center_y    = rsp_center_y_ff;
   assign rsp_pixel_count = rsp_count_ff;
   assign rsp_ref_energy  = $signed(rsp_ref_ff);
   assign rsp_test_energy = $signed(rsp_test_ff);

   // ------------------------------------------------------------ assertions
   `ASSERT_IMPLY(a_div_nonzero, clock, reset, div_step, (count_ff != '0))
   `ASSERT_NEXT(a_emit_clears, clock, reset, emit_fire, (count_ff == '0 && col_sum_ff == '0))
   `ASSERT_IMPLY(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff), ($past(state_ff) == ST_EMIT))
   `ASSERT_ALWAYS(a_step_range, clock, reset, (step_ff <= DIV_LAST))

endmodule

// File: verif/wtce_frame_checker.sv
// Scoreboard for the windowed centroid block: tracks registers, predicts each frame, compares.
`timescale 1ns / 1ps

module wtce_frame_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [wtce_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wtce_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [wtce_pkg::PIX_W-1:0]         req_pixel,
   input  logic [wtce_pkg::COORD_W-1:0]       req_col,
   input  logic [wtce_pkg::COORD_W-1:0]       req_row,
   input  logic                               req_frame_end,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [wtce_pkg::CEN_W-1:0]         rsp_center_x,
   input  logic [wtce_pkg::CEN_W-1:0]         rsp_center_y,
   input  logic [wtce_pkg::CNT_W-1:0]         rsp_pixel_count,
   input  logic signed [wtce_pkg::NRG_W-1:0]  rsp_ref_energy,
   input  logic signed [wtce_pkg::NRG_W-1:0]  rsp_test_energy,
   output int                                 fail_count,
   output int                                 results_owed
);

   import wtce_pkg::*;

   typedef struct packed {
      logic [CEN_W-1:0]         cx;
      logic [CEN_W-1:0]         cy;
      logic [CNT_W-1:0]         cnt;
      logic signed [NRG_W-1:0]  e_ref;
      logic signed [NRG_W-1:0]  e_test;
   } frame_result_type;

   frame_result_type owed_frames[$];
   int errors = 0;

   // shadow registers
   logic [THR_W-1:0]         thr;
   logic signed [WIN_W-1:0]  win_l, win_t, win_r, win_b;
   logic [PIX_W-1:0]         noise_ref, noise_test;

   // per-frame sums
   logic [CNT_W-1:0]  n_acc;
   logic [SUM_W-1:0]  x_acc, y_acc;
   logic [ACC_W-1:0]  e_ref_acc, e_test_acc;

   assign fail_count = errors;

   // truncating mean in Q.8 plus one half
   function automatic logic [CEN_W-1:0] q8_mean(input logic [SUM_W-1:0] sum,
                                                input logic [CNT_W-1:0] cnt);
      logic [63:0] q;
      q = ({30'd0, sum} << FRAC_W) / {41'd0, cnt} + 64'(HALF_Q8);
      return q[CEN_W-1:0];
   endfunction

   function automatic int mismatch(input string name, input logic signed [63:0] want,
                                   input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      frame_result_type want;
      int x0, x1, y0, y1;
      if (reset) begin
         thr        = THRESHOLD_RST;
         win_l      = '0;
         win_t      = '0;
         win_r      = WIN_END_RST;
         win_b      = WIN_END_RST;
         noise_ref  = '0;
         noise_test = '0;
         n_acc      = '0;
         x_acc      = '0;
         y_acc      = '0;
         e_ref_acc  = '0;
         e_test_acc = '0;
         owed_frames.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_frames.size() == 0) begin
               $error("result with no frame outstanding: count %0d", rsp_pixel_count);
               errors++;
            end else begin
               want = owed_frames.pop_front();
               errors += mismatch("center_x", want.cx, rsp_center_x);
               errors += mismatch("center_y", want.cy, rsp_center_y);
               errors += mismatch("pixel_count", want.cnt, rsp_pixel_count);
               errors += mismatch("ref_energy", want.e_ref, rsp_ref_energy);
               errors += mismatch("test_energy", want.e_test, rsp_test_energy);
            end
         end

         if (req_valid && !req_stall) begin
            x0 = int'(win_l);
            y0 = int'(win_t);
            x1 = int'(win_r);
            y1 = int'(win_b);
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (x1 > IMG_W - 1) x1 = IMG_W - 1;
            if (y1 > IMG_H - 1) y1 = IMG_H - 1;
            if (int'(req_col) >= x0 && int'(req_col) < x1 &&
                int'(req_row) >= y0 && int'(req_row) < y1 &&
                {1'b0, req_pixel} >= thr) begin
               n_acc      = n_acc + CNT_W'(1);
               x_acc      = x_acc + SUM_W'(req_col);
               y_acc      = y_acc + SUM_W'(req_row);
               e_ref_acc  = e_ref_acc + ACC_W'(req_pixel) - ACC_W'(noise_ref);
               e_test_acc = e_test_acc + ACC_W'(req_pixel) - ACC_W'(noise_test);
            end
            if (req_frame_end) begin
               want.cx     = (n_acc != 0) ? q8_mean(x_acc, n_acc) : '0;
               want.cy     = (n_acc != 0) ? q8_mean(y_acc, n_acc) : '0;
               want.cnt    = n_acc;
               want.e_ref  = e_ref_acc[NRG_W-1:0];
               want.e_test = e_test_acc[NRG_W-1:0];
               owed_frames.push_back(want);
               n_acc      = '0;
               x_acc      = '0;
               y_acc      = '0;
               e_ref_acc  = '0;
               e_test_acc = '0;
            end
         end

         if (csr_write) begin
            case (csr_index)
               REG_THRESHOLD:  thr        = csr_wdata[THR_W-1:0];
               REG_WIN_LEFT:   win_l      = csr_wdata;
               REG_WIN_TOP:    win_t      = csr_wdata;
               REG_WIN_RIGHT:  win_r      = csr_wdata;
               REG_WIN_BOTTOM: win_b      = csr_wdata;
               REG_REF_NOISE:  noise_ref  = csr_wdata[PIX_W-1:0];
               REG_TEST_NOISE: noise_test = csr_wdata[PIX_W-1:0];
               default: ;
            endcase
         end
      end
      results_owed <= owed_frames.size();
   end

endmodule

// File: verif/window_threshold_centroid_energy_top_tb.sv
// Stimulus and verdict for the windowed thresholded centroid and energy block.
`timescale 1ns / 1ps

module window_threshold_centroid_energy_top_tb;
   import wtce_pkg::*;

   // index past the register list; writes there must leave everything alone
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   // receiver back-pressure styles
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_HALF,
      STALL_HEAVY,
      STALL_LIGHT
   } stall_mode_type;

   // one full register setting
   typedef struct {
      logic [THR_W-1:0]         thr;
      logic signed [WIN_W-1:0]  left;
      logic signed [WIN_W-1:0]  top;
      logic signed [WIN_W-1:0]  right;
      logic signed [WIN_W-1:0]  bottom;
      logic [PIX_W-1:0]         ref_noise;
      logic [PIX_W-1:0]         test_noise;
   } settings_type;

   logic                     clock;
   logic                     reset         = 1'b1;
   logic                     csr_write     = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index     = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata     = '0;
   logic                     req_valid     = 1'b0;
   logic                     req_stall;
   logic [PIX_W-1:0]         req_pixel     = '0;
   logic [COORD_W-1:0]       req_col       = '0;
   logic [COORD_W-1:0]       req_row       = '0;
   logic                     req_frame_end = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall     = 1'b0;
   logic [CEN_W-1:0]         rsp_center_x;
   logic [CEN_W-1:0]         rsp_center_y;
   logic [CNT_W-1:0]         rsp_pixel_count;
   logic signed [NRG_W-1:0]  rsp_ref_energy;
   logic signed [NRG_W-1:0]  rsp_test_energy;

   int fail_count;
   int results_owed;

   // sender bookkeeping
   int           items_sent = 0;
   int           burst_left = 0;
   settings_type cur;

   // receiver stall pattern
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   window_threshold_centroid_energy_top dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_center_x    (rsp_center_x),
      .rsp_center_y    (rsp_center_y),
      .rsp_pixel_count (rsp_pixel_count),
      .rsp_ref_energy  (rsp_ref_energy),
      .rsp_test_energy (rsp_test_energy)
   );

   wtce_frame_checker frame_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_center_x    (rsp_center_x),
      .rsp_center_y    (rsp_center_y),
      .rsp_pixel_count (rsp_pixel_count),
      .rsp_ref_energy  (rsp_ref_energy),
      .rsp_test_energy (rsp_test_energy),
      .fail_count      (fail_count),
      .results_owed    (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: switch between stall styles after a random hold of each,
   // so gaps land on every phase of the divider and of the result hold.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 300);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 1);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) != 0);
         default:     rsp_stall <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic settings_type make_settings(input int thr, input int left, input int top,
                                                  input int right, input int bottom,
                                                  input int rn, input int tn);
      settings_type s;
      s.thr        = THR_W'(thr);
      s.left       = WIN_W'(left);
      s.top        = WIN_W'(top);
      s.right      = WIN_W'(right);
      s.bottom     = WIN_W'(bottom);
      s.ref_noise  = PIX_W'(rn);
      s.test_noise = PIX_W'(tn);
      return s;
   endfunction

   // Mostly usable windows, now and then any 13-bit value (clamped, inverted, empty).
   function automatic settings_type random_settings();
      settings_type s;
      case ($urandom_range(0, 7))
         0:       s.thr = '0;
         1:       s.thr = 9'd256;
         default: s.thr = THR_W'($urandom_range(0, 255));
      endcase
      s.left   = ($urandom_range(0, 5) == 0) ? WIN_W'($urandom_range(0, 8191))
                                             : WIN_W'($urandom_range(0, 1500));
      s.top    = ($urandom_range(0, 5) == 0) ? WIN_W'($urandom_range(0, 8191))
                                             : WIN_W'($urandom_range(0, 1500));
      s.right  = ($urandom_range(0, 5) == 0) ? WIN_W'($urandom_range(0, 8191))
                                             : s.left + WIN_W'($urandom_range(1, 600));
      s.bottom = ($urandom_range(0, 5) == 0) ? WIN_W'($urandom_range(0, 8191))
                                             : s.top + WIN_W'($urandom_range(1, 600));
      s.ref_noise  = PIX_W'($urandom_range(0, 255));
      s.test_noise = PIX_W'($urandom_range(0, 255));
      return s;
   endfunction

   // Coordinate aimed at the clamped window span and just past its edges,
   // with a quarter drawn over the full coordinate range.
   function automatic logic [COORD_W-1:0] aim(input int lo, input int hi, input int lim);
      int a, b;
      if (lo < 0) lo = 0;
      if (hi > lim - 1) hi = lim - 1;
      a = (lo - 2 < 0) ? 0 : lo - 2;
      b = (hi + 1 > lim - 1) ? lim - 1 : hi + 1;
      if (a > b || $urandom_range(0, 3) == 0)
         return COORD_W'($urandom_range(0, lim - 1));
      return COORD_W'($urandom_range(a, b));
   endfunction

   // Present one request and hold it until taken; bursts end in a random gap.
   task automatic send_pixel(input logic [PIX_W-1:0] p, input logic [COORD_W-1:0] c,
                             input logic [COORD_W-1:0] r, input logic fe);
      req_valid     <= 1'b1;
      req_pixel     <= p;
      req_col       <= c;
      req_row       <= r;
      req_frame_end <= fe;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   // Stop sending and wait until every frame result is back, then let the
   // divider run out its longest pass. Doubles as the end-of-run drain.
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) begin
         @(posedge clock);
         waited++;
         if (waited > 20000) begin
            $display("simulation failed");
            $finish;
         end
      end
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Registers only change with the block idle; write enable stays high
   // across the whole sequence and drops once at the end.
   task automatic load_settings(input settings_type s);
      settle();
      csr_put(REG_THRESHOLD,  CSR_DATA_W'(s.thr));
      csr_put(REG_WIN_LEFT,   s.left);
      csr_put(REG_WIN_TOP,    s.top);
      csr_put(REG_WIN_RIGHT,  s.right);
      csr_put(REG_WIN_BOTTOM, s.bottom);
      csr_put(REG_REF_NOISE,  CSR_DATA_W'(s.ref_noise));
      csr_put(REG_TEST_NOISE, CSR_DATA_W'(s.test_noise));
      if ($urandom_range(0, 3) == 0)
         csr_put(REG_UNUSED, CSR_DATA_W'($urandom_range(0, 8191)));
      csr_write <= 1'b0;
      cur = s;
   endtask

   // A random frame; the last request carries the frame-end mark.
   task automatic send_frame(input int len);
      logic [PIX_W-1:0] p;
      int pick;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 2 && cur.thr != 0 && cur.thr <= 255)
            p = PIX_W'(cur.thr - 1 + pick);     // straddle the threshold
         else
            p = PIX_W'($urandom_range(0, 255));
         send_pixel(p, aim(int'(cur.left), int'(cur.right), IMG_W),
                    aim(int'(cur.top), int'(cur.bottom), IMG_H), i == len - 1);
      end
   endtask

   initial begin
      cur = make_settings(128, 0, 0, 2047, 2047, 0, 0);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // reset values: single counted pixel at the origin
      send_pixel(8'd255, 11'd0, 11'd0, 1'b1);
      // one pixel just under the threshold: empty frame, zero centroid
      send_pixel(8'd127, 11'd5, 11'd5, 1'b1);
      // pixel at threshold on the last counted column/row; the edge column is excluded
      send_pixel(8'd128, 11'd2046, 11'd2046, 1'b0);
      send_pixel(8'd200, 11'd2047, 11'd5, 1'b0);
      send_pixel(8'd0, 11'd1000, 11'd1000, 1'b1);
      send_pixel(8'd255, 11'd2046, 11'd0, 1'b0);
      send_pixel(8'd128, 11'd0, 11'd2046, 1'b0);
      send_pixel(8'd200, 11'd1, 11'd1, 1'b1);

      // threshold zero, negative starts clamp to zero, oversized end clamps,
      // full reference noise drives the energy negative
      load_settings(make_settings(0, -4096, -1, 4095, 2047, 255, 0));
      send_pixel(8'd0, 11'd0, 11'd0, 1'b0);
      send_pixel(8'd0, 11'd2047, 11'd2047, 1'b0);
      send_pixel(8'd255, 11'd100, 11'd7, 1'b0);
      send_pixel(8'd0, 11'd5, 11'd5, 1'b1);

      // threshold above every gray level: nothing counts
      load_settings(make_settings(256, 0, 0, 2047, 2047, 0, 255));
      send_pixel(8'd255, 11'd10, 11'd10, 1'b0);
      send_pixel(8'd255, 11'd20, 11'd20, 1'b1);

      // inverted column window
      load_settings(make_settings(0, 500, 0, 100, 2047, 17, 99));
      send_pixel(8'd100, 11'd300, 11'd300, 1'b0);
      send_pixel(8'd50, 11'd600, 11'd600, 1'b1);

      // two-by-two window, probing every edge
      load_settings(make_settings(1, 10, 20, 12, 22, 3, 200));
      send_pixel(8'd1, 11'd10, 11'd20, 1'b0);
      send_pixel(8'd9, 11'd11, 11'd21, 1'b0);
      send_pixel(8'd7, 11'd12, 11'd21, 1'b0);
      send_pixel(8'd5, 11'd11, 11'd22, 1'b0);
      send_pixel(8'd0, 11'd10, 11'd20, 1'b1);

      // --- random part: short frames under a run of register settings ---
      while (items_sent < 1200) begin
         load_settings(random_settings());
         repeat ($urandom_range(3, 12))
            send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(1, 200)
                                                   : $urandom_range(1, 24));
      end

      settle();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: window_threshold_centroid_energy_top.f
+incdir+hw/rtl
hw/rtl/wtce_pkg.sv
hw/rtl/window_threshold_centroid_energy_top.sv
verif/wtce_frame_checker.sv
verif/window_threshold_centroid_energy_top_tb.sv
